[sv/go_to_goal_heading_controller_core_assert.svh]
// Assertion macros shared by the go-to-goal heading controller RTL.
// Depends on nothing; included by the control and datapath modules.
`ifndef GO_TO_GOAL_HEADING_CONTROLLER_CORE_ASSERT_SVH
`define GO_TO_GOAL_HEADING_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define GTGHC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GTGHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/gtghc_pkg.sv]
// Types and constants of the go-to-goal heading controller.
// Used by gtghc_ctrl, gtghc_dpath and the top level; depends on nothing.
package gtghc_pkg;

   typedef struct packed {
      logic signed [15:0] pose_x;
      logic signed [15:0] pose_y;
      logic signed [15:0] heading;
      logic               new_goal;
      logic signed [15:0] goal_x;
      logic signed [15:0] goal_y;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] linear_velocity;
      logic signed [15:0] angular_velocity;
      logic               moving;
   } rsp_payload_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic       load;     // capture pose, update target, form dx/dy
      logic       sq_x;     // product <= dx*dx
      logic       sq_y;     // product <= dy*dy, keep dx*dx
      logic       init;     // sum squares, seed root and CORDIC
      logic       iso_en;   // one square-root digit
      logic       cor_en;   // one CORDIC micro-rotation
      logic [4:0] idx;      // CORDIC shift / table index
      logic       wrap;     // round bearing, subtract heading, wrap
      logic       mul;      // gain product and branch decision
      logic       publish;  // load the result register
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;       // result register can take a transaction
   } dp_status_type;

   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR_GAIN       = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_GAIN         = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADING_TOLERANCE = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRIVE_DISTANCE   = 8'd3;

   localparam logic [15:0] LINEAR_GAIN_RST       = 16'd8192;
   localparam logic [15:0] TURN_GAIN_RST         = 16'd8192;
   localparam logic [14:0] HEADING_TOLERANCE_RST = 15'd819;
   localparam logic [14:0] ARRIVE_DISTANCE_RST   = 15'd154;
   localparam logic signed [15:0] TARGET_RST     = 16'sd5673;

   localparam int MAX_ITER   = 24;
   localparam int SQRT_STEPS = 17;   // 34-bit radicand, two bits per digit

   localparam logic signed [18:0] PI_Q13     = 19'sd25736;
   localparam logic signed [18:0] TWO_PI_Q13 = 19'sd51472;
   localparam logic signed [20:0] PI_Q16     = 21'sd205887;

   // Arctangent of 2^-i in units of 2^-16 rad.
   function automatic logic [16:0] atan_lookup(input logic [4:0] i);
      logic [16:0] v;
      unique case (i)
         5'd0:    v = 17'd51472;
         5'd1:    v = 17'd30385;
         5'd2:    v = 17'd16055;
         5'd3:    v = 17'd8150;
         5'd4:    v = 17'd4091;
         5'd5:    v = 17'd2047;
         5'd6:    v = 17'd1024;
         5'd7:    v = 17'd512;
         5'd8:    v = 17'd256;
         5'd9:    v = 17'd128;
         5'd10:   v = 17'd64;
         5'd11:   v = 17'd32;
         5'd12:   v = 17'd16;
         5'd13:   v = 17'd8;
         5'd14:   v = 17'd4;
         5'd15:   v = 17'd2;
         5'd16:   v = 17'd1;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

[sv/gtghc_ctrl.sv]
// Sequencer of the go-to-goal heading controller: one-hot state machine
// and iteration counter. Depends on gtghc_pkg and the assertion header.
`include "go_to_goal_heading_controller_core_assert.svh"

module gtghc_ctrl #(
   parameter int CORDIC_STEPS = 14
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  gtghc_pkg::dp_status_type status,
   output gtghc_pkg::dp_cmd_type    cmd
);

   localparam int ITERS = (CORDIC_STEPS > gtghc_pkg::MAX_ITER) ?
                          gtghc_pkg::MAX_ITER : CORDIC_STEPS;
   localparam int LOOP  = (ITERS > gtghc_pkg::SQRT_STEPS) ? ITERS : gtghc_pkg::SQRT_STEPS;
   localparam int CW    = $clog2(LOOP);
   localparam logic [CW-1:0] LAST = CW'(LOOP - 1);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_SQX  = 8'b0000_0010,
      S_SQY  = 8'b0000_0100,
      S_INIT = 8'b0000_1000,
      S_ITER = 8'b0001_0000,
      S_WRAP = 8'b0010_0000,
      S_MUL  = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.idx  = 5'(cnt_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            cmd.sq_x = 1'b1;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.sq_y = 1'b1;
            state_in = S_INIT;
         end
         S_INIT: begin
            cmd.init = 1'b1;
            cnt_in   = '0;
            state_in = S_ITER;
         end
         S_ITER: begin
            cmd.iso_en = (cnt_ff < CW'(gtghc_pkg::SQRT_STEPS));
            cmd.cor_en = (cnt_ff < CW'(ITERS));
            if (cnt_ff == LAST) begin
               state_in = S_WRAP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_WRAP: begin
            cmd.wrap = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the result register frees up
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   `GTGHC_ASSERT_NEXT(a_publish_returns_idle, clock, reset, cmd.publish,
      state_ff == S_IDLE, "sequencer did not return to idle after publish")
   `GTGHC_ASSERT_NEXT(a_loop_exits, clock, reset, (state_ff == S_ITER) && (cnt_ff == LAST),
      state_ff == S_WRAP, "iteration loop did not end on its last step")

endmodule

[sv/gtghc_dpath.sv]
// Datapath of the go-to-goal heading controller: target and config registers,
// shared multiplier, square root, CORDIC, wrap and saturation, result register.
// Depends on gtghc_pkg and the assertion header.
`include "go_to_goal_heading_controller_core_assert.svh"

module gtghc_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gtghc_pkg::dp_cmd_type                cmd,
   output gtghc_pkg::dp_status_type             status,
   input  gtghc_pkg::req_payload_type           req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output gtghc_pkg::rsp_payload_type           rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gtghc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [15:0]                          csr_data
);

   localparam int XW = 28;   // CORDIC x/y
   localparam int ZW = 21;   // CORDIC angle, 2^-16 rad
   localparam int EW = 19;   // heading error, Q3.13
   localparam int PW = 36;   // product

   // configuration
   logic [15:0] lin_gain_ff, turn_gain_ff;
   logic [14:0] tol_ff, arrive_ff;

   // item state
   logic signed [15:0] tgt_x_ff, tgt_y_ff, tgt_x_in, tgt_y_in;
   logic               active_ff, active_in;
   logic signed [16:0] dx_ff, dy_ff, dx_in, dy_in;
   logic signed [15:0] hd_ff;
   logic               zero_ff;

   // multiplier
   logic signed [16:0]   mul_a;
   logic signed [EW-1:0] mul_b;
   logic signed [PW-1:0] mul_p, prod_ff, sum_ff;

   // square root
   logic [33:0] rad_ff;
   logic [20:0] rem_ff, rem_sh, trial;
   logic [16:0] root_ff;

   // CORDIC
   logic signed [XW-1:0] x_ff, y_ff, x0, y0, xs, ys;
   logic signed [ZW-1:0] z_ff, z0, at, zr;

   // wrap and decision
   logic signed [17:0]   bear;
   logic signed [EW-1:0] e0, e1, e2, err_ff, aerr;
   logic                 go_ff, fwd_ff, fwd;

   // saturation
   logic signed [PW-1:0] lin_t, ang_t, lin_s, ang_s;
   logic signed [15:0]   lin_v, ang_v;

   logic                       rsp_valid_ff;
   gtghc_pkg::rsp_payload_type rsp_ff;

   assign csr_ready       = 1'b1;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

   // configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         lin_gain_ff  <= gtghc_pkg::LINEAR_GAIN_RST;
         turn_gain_ff <= gtghc_pkg::TURN_GAIN_RST;
         tol_ff       <= gtghc_pkg::HEADING_TOLERANCE_RST;
         arrive_ff    <= gtghc_pkg::ARRIVE_DISTANCE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            gtghc_pkg::CSR_LINEAR_GAIN:       lin_gain_ff  <= csr_data;
            gtghc_pkg::CSR_TURN_GAIN:         turn_gain_ff <= csr_data;
            gtghc_pkg::CSR_HEADING_TOLERANCE: tol_ff       <= csr_data[14:0];
            gtghc_pkg::CSR_ARRIVE_DISTANCE:   arrive_ff    <= csr_data[14:0];
            default: begin
            end
         endcase
      end
   end

   // target and offset
   always_comb begin
      tgt_x_in = tgt_x_ff;
      tgt_y_in = tgt_y_ff;
      if (cmd.load && req_data.new_goal) begin
         tgt_x_in = req_data.goal_x;
         tgt_y_in = req_data.goal_y;
      end
      dx_in = 17'(tgt_x_in) - 17'(req_data.pose_x);
      dy_in = 17'(tgt_y_in) - 17'(req_data.pose_y);
   end

   always_comb begin
      active_in = active_ff;
      if (cmd.load && req_data.new_goal) begin
         active_in = 1'b1;
      end else if (cmd.publish && !go_ff) begin
         active_in = 1'b0;
      end
   end

   // shared multiplier
   assign aerr = err_ff[EW-1] ? -err_ff : err_ff;
   assign fwd  = (aerr < EW'(tol_ff));

   always_comb begin
      priority if (cmd.sq_x) begin
         mul_a = dx_ff;
         mul_b = EW'(dx_ff);
      end else if (cmd.sq_y) begin
         mul_a = dy_ff;
         mul_b = EW'(dy_ff);
      end else if (fwd) begin
         mul_a = {1'b0, lin_gain_ff};
         mul_b = {2'b00, root_ff};
      end else begin
         mul_a = {1'b0, turn_gain_ff};
         mul_b = err_ff;
      end
      mul_p = PW'(mul_a) * PW'(mul_b);
   end

   // square-root digit
   assign rem_sh = {rem_ff[18:0], rad_ff[33:32]};
   assign trial  = {2'b00, root_ff, 2'b01};

   // CORDIC seed: fold the left half plane by 180 degrees
   always_comb begin
      x0 = XW'(dx_ff) <<< 8;
      y0 = XW'(dy_ff) <<< 8;
      z0 = '0;
      if (dx_ff[16]) begin
         x0 = -x0;
         y0 = -y0;
         z0 = dy_ff[16] ? -gtghc_pkg::PI_Q16 : gtghc_pkg::PI_Q16;
      end
   end

   assign xs = x_ff >>> cmd.idx;
   assign ys = y_ff >>> cmd.idx;
   assign at = ZW'(gtghc_pkg::atan_lookup(cmd.idx));

   // bearing to Q3.13, error, single wrap
   always_comb begin
      zr   = z_ff + ZW'(4);
      bear = zero_ff ? 18'sd0 : 18'(zr >>> 3);
      e0   = EW'(bear) - EW'(hd_ff);
      e1   = (e0 > gtghc_pkg::PI_Q13) ? e0 - gtghc_pkg::TWO_PI_Q13 : e0;
      e2   = (e1 < -gtghc_pkg::PI_Q13) ? e1 + gtghc_pkg::TWO_PI_Q13 : e1;
   end

   // round and saturate the gain product
   always_comb begin
      lin_t = prod_ff + PW'(8192);
      lin_s = lin_t >>> 14;
      ang_t = prod_ff + PW'(65536);
      ang_s = ang_t >>> 17;
      lin_v = (lin_s > PW'(32767)) ? 16'sd32767 : 16'(lin_s);
      priority if (ang_s > PW'(32767)) begin
         ang_v = 16'sd32767;
      end else if (ang_s < -PW'(32768)) begin
         ang_v = -16'sd32768;
      end else begin
         ang_v = 16'(ang_s);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_x_ff     <= gtghc_pkg::TARGET_RST;
         tgt_y_ff     <= gtghc_pkg::TARGET_RST;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tgt_x_ff  <= tgt_x_in;
         tgt_y_ff  <= tgt_y_in;
         active_ff <= active_in;
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         hd_ff   <= req_data.heading;
         zero_ff <= (dx_in == '0) && (dy_in == '0);
      end
      if (cmd.sq_x || cmd.sq_y || cmd.mul) begin
         prod_ff <= mul_p;
      end
      if (cmd.sq_y) begin
         sum_ff <= prod_ff;
      end
      if (cmd.init) begin
         rad_ff  <= sum_ff[33:0] + prod_ff[33:0];
         rem_ff  <= '0;
         root_ff <= '0;
         x_ff    <= x0;
         y_ff    <= y0;
         z_ff    <= z0;
      end
      if (cmd.iso_en) begin
         rad_ff <= {rad_ff[31:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[15:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[15:0], 1'b0};
         end
      end
      if (cmd.cor_en) begin
         if (!y_ff[XW-1]) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + at;
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - at;
         end
      end
      if (cmd.wrap) begin
         err_ff <= e2;
         go_ff  <= active_ff && (root_ff > 17'(arrive_ff));
      end
      if (cmd.mul) begin
         fwd_ff <= fwd;
      end
      if (cmd.publish) begin
         rsp_ff.moving           <= go_ff;
         rsp_ff.linear_velocity  <= (go_ff && fwd_ff) ? lin_v : 16'sd0;
         rsp_ff.angular_velocity <= (go_ff && !fwd_ff) ? ang_v : 16'sd0;
      end
   end

   `GTGHC_ASSERT_NOW(a_idle_is_zero, clock, reset, rsp_valid_ff && !rsp_ff.moving,
      (rsp_ff.linear_velocity == '0) && (rsp_ff.angular_velocity == '0),
      "stopped result carries a nonzero velocity")
   `GTGHC_ASSERT_NOW(a_one_branch, clock, reset, rsp_valid_ff && (rsp_ff.linear_velocity != '0),
      rsp_ff.angular_velocity == '0, "drive and turn commanded together")
   `GTGHC_ASSERT_NEXT(a_publish_valid, clock, reset, cmd.publish,
      rsp_valid_ff && (rsp_ff.moving == active_ff), "published result lost or flag mismatch")

endmodule

[sv/go_to_goal_heading_controller_core.sv]
// Go-to-goal heading controller. One transaction at a time: the next request is taken
// once the previous result is in the result register. The shared iteration loop runs
// 17 square-root digits beside the CORDIC steps.
// Synchronous active-high reset: gains 0.5, tolerance 819, arrive 154, target (5.54, 5.54),
// waypoint disarmed, no result pending.
module go_to_goal_heading_controller_core #(
   parameter int CORDIC_STEPS = 14
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel: pose and optional new goal
   input  logic                            req_valid,
   output logic                            req_ready,
   input  gtghc_pkg::req_payload_type      req_data,
   // response channel: velocity commands
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output gtghc_pkg::rsp_payload_type      rsp_data,
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gtghc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                     csr_data
);

   // Command and status between sequencer and datapath.
   gtghc_pkg::dp_cmd_type    cmd;
   gtghc_pkg::dp_status_type status;

   // Sequencer: accept a transaction in idle, step the datapath through
   // squares, root/CORDIC loop, wrap, gain multiply, then publish.
   gtghc_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: holds the target, config and result register; the result
   // register lets the next request in while a response still waits.
   gtghc_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule
